FILE: src/dcet_pkg.sv
// shared types, constants and the envelope update function for the envelope tracker
`default_nettype none

package dcet_pkg;

  localparam int SampleBits = 18;
  localparam int ShiftBits  = 4;
  localparam logic [ShiftBits-1:0] ShiftReset = ShiftBits'(4);

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [ShiftBits-1:0]  shift_t;

  typedef struct packed {
    sample_t ir_sample;
    sample_t red_sample;
    sample_t ir_background;
    logic    restart;
  } in_item_t;

  typedef struct packed {
    sample_t ir_excess;
    sample_t ir_span;
    sample_t red_span;
  } out_item_t;

  // one envelope update: jump on empty or break-through, otherwise decay toward the sample
  function automatic sample_t track_env(sample_t env, sample_t s, shift_t shift, logic upper);
    sample_t gap;
    sample_t step;
    logic    breaks;
    breaks = upper ? (s >= env) : (s <= env);
    if ((env == '0) || breaks) begin
      return s;
    end
    gap  = upper ? (env - s) : (s - env);
    step = gap >> shift;
    if (step == '0) begin
      step = SampleBits'(1);
    end
    return upper ? (env - step) : (env + step);
  endfunction

endpackage

`default_nettype wire

FILE: src/dcet_chan.sv
// high and low envelope registers of one channel with their update and span logic
`default_nettype none

module dcet_chan
  import dcet_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    advance,
  input  wire logic    restart,
  input  wire sample_t sample,
  input  wire shift_t  follow_shift,
  output sample_t      span
);

  sample_t upper;
  sample_t lower;
  sample_t upper_base;
  sample_t lower_base;
  sample_t upper_next;
  sample_t lower_next;

  always_comb begin
    upper_base = restart ? '0 : upper;
    lower_base = restart ? '0 : lower;
    upper_next = track_env(upper_base, sample, follow_shift, 1'b1);
    lower_next = track_env(lower_base, sample, follow_shift, 1'b0);
    span       = (upper_next >= lower_next) ? (upper_next - lower_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper <= '0;
      lower <= '0;
    end else if (advance) begin
      upper <= upper_next;
      lower <= lower_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/dual_channel_envelope_tracker.sv
// top level of the dual channel envelope tracker
//
// each input item carries an ir sample, a red sample, the ir background level and
// a restart flag; each item gives exactly one result item with the ir excess over
// the background and the high-minus-low span of each channel's envelopes.
// both channels use valid and stall; an item moves on an edge with valid high and
// stall low. the item is held in an input register, the envelope update runs in
// combinational logic, and the result lands in an output register.
// throughput: one item per cycle while the receiver does not stall.
// when the receiver stalls, the result holds in the output register and one more
// item is still taken into the input register; stall then reaches the sender.
// follow_shift is written through cfg_wen/cfg_wdata; the user must write it only
// while the block is idle, which the block does not enforce. reset empties all four
// envelopes, drops any items in flight and sets follow_shift to 4.
`default_nettype none

module dual_channel_envelope_tracker
  import dcet_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item,
  input  wire logic      cfg_wen,
  input  wire shift_t    cfg_wdata
);

  shift_t    follow_shift;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_advance;
  logic      in_take;
  sample_t   ir_span;
  sample_t   red_span;
  out_item_t result_next;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && out_valid && out_stall;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      follow_shift <= ShiftReset;
    end else if (cfg_wen) begin
      follow_shift <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= in_item;
    end
  end

  dcet_chan u_ir (
    .clk          (clk),
    .rst          (rst),
    .advance      (s1_advance),
    .restart      (s1_item.restart),
    .sample       (s1_item.ir_sample),
    .follow_shift (follow_shift),
    .span         (ir_span)
  );

  dcet_chan u_red (
    .clk          (clk),
    .rst          (rst),
    .advance      (s1_advance),
    .restart      (s1_item.restart),
    .sample       (s1_item.red_sample),
    .follow_shift (follow_shift),
    .span         (red_span)
  );

  always_comb begin
    result_next.ir_excess = (s1_item.ir_sample > s1_item.ir_background) ?
                            (s1_item.ir_sample - s1_item.ir_background) : '0;
    result_next.ir_span   = ir_span;
    result_next.red_span  = red_span;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_item <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/dcet_checker.sv
// port-level checker for the envelope tracker and its bind
`default_nettype none

module dcet_checker
  import dcet_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // a stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed");

  // the sender is held back only while a result is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no stalled result");

  // an accepted item yields a valid result if the output is free while it sits in the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted item not delivered");

endmodule

bind dual_channel_envelope_tracker dcet_checker u_dcet_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the dual channel envelope tracker
module tb_top;
  import dcet_pkg::*;

  localparam int SampleMax = (1 << SampleBits) - 1;
  localparam int ReportLimit = 10;
  localparam int InBits = $bits(in_item_t);

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_wen = 1'b0;
  shift_t    cfg_wdata = ShiftReset;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int ir_level = 0;
  int red_level = 0;

  shift_t    follow_shift_q = ShiftReset;
  sample_t   ir_upper_q = '0;
  sample_t   ir_lower_q = '0;
  sample_t   red_upper_q = '0;
  sample_t   red_lower_q = '0;
  out_item_t expected_spans[$];

  dual_channel_envelope_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_idle_pct);
  end

  // envelope step: jump when empty or broken through, else close the gap by a fraction
  function automatic sample_t follow_envelope(sample_t env, sample_t s, logic is_upper);
    sample_t gap_len;
    sample_t delta;
    if (env == '0 || (is_upper ? (s >= env) : (s <= env))) begin
      return s;
    end
    gap_len = (env > s) ? env - s : s - env;
    delta   = gap_len >> follow_shift_q;
    if (delta == '0) begin
      delta = sample_t'(1);
    end
    return (env > s) ? env - delta : env + delta;
  endfunction

  function automatic out_item_t advance_envelopes(in_item_t it);
    out_item_t r;
    if (it.restart) begin
      ir_upper_q  = '0;
      ir_lower_q  = '0;
      red_upper_q = '0;
      red_lower_q = '0;
    end
    ir_upper_q  = follow_envelope(ir_upper_q, it.ir_sample, 1'b1);
    ir_lower_q  = follow_envelope(ir_lower_q, it.ir_sample, 1'b0);
    red_upper_q = follow_envelope(red_upper_q, it.red_sample, 1'b1);
    red_lower_q = follow_envelope(red_lower_q, it.red_sample, 1'b0);
    r.ir_excess = (it.ir_sample > it.ir_background) ? it.ir_sample - it.ir_background : '0;
    r.ir_span   = (ir_upper_q >= ir_lower_q) ? ir_upper_q - ir_lower_q : '0;
    r.red_span  = (red_upper_q >= red_lower_q) ? red_upper_q - red_lower_q : '0;
    return r;
  endfunction

  function automatic in_item_t sample_set(int ir, int red, int bg, bit rs);
    in_item_t it;
    it.ir_sample     = sample_t'(ir);
    it.red_sample    = sample_t'(red);
    it.ir_background = sample_t'(bg);
    it.restart       = rs;
    return it;
  endfunction

  function automatic int clamp_sample(int v);
    return (v < 0) ? 0 : ((v > SampleMax) ? SampleMax : v);
  endfunction

  function automatic int wander(int level);
    int next_level;
    case ($urandom_range(19))
      0: next_level = 0;
      1: next_level = SampleMax;
      2: next_level = int'($urandom_range(SampleMax));
      default: next_level = level + int'($urandom_range(4000)) - 2000;
    endcase
    return clamp_sample(next_level);
  endfunction

  task automatic send_sample(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_spans.push_back(advance_envelopes(it));
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk);
  endtask

  task automatic set_follow_shift(input shift_t v);
    hold_until_drained();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    follow_shift_q = v;
  endtask

  task automatic compare_field(input string name, input sample_t want, input sample_t got);
    if (want !== got) begin
      if (mismatch_count < ReportLimit) begin
        $display("%s differs: expected %0d, got %0d", name, want, got);
      end
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_spans.size() == 0) begin
        if (mismatch_count < ReportLimit) begin
          $display("result item with none expected: excess %0d ir span %0d red span %0d",
                   out_item.ir_excess, out_item.ir_span, out_item.red_span);
        end
        mismatch_count++;
      end else begin
        want = expected_spans.pop_front();
        compare_field("ir_excess", want.ir_excess, out_item.ir_excess);
        compare_field("ir_span", want.ir_span, out_item.ir_span);
        compare_field("red_span", want.red_span, out_item.red_span);
      end
    end
  end

  // mostly slow wandering signals, with jumps, rails, zeros and the odd restart
  task automatic make_random_item(output in_item_t it);
    int pick;
    int bg;
    pick = $urandom_range(99);
    if (pick < 8) begin
      it = in_item_t'(InBits'({$urandom, $urandom}));
      ir_level  = int'(it.ir_sample);
      red_level = int'(it.red_sample);
    end else begin
      ir_level  = wander(ir_level);
      red_level = wander(red_level);
      case ($urandom_range(3))
        0: bg = ir_level;
        1: bg = clamp_sample(ir_level - int'($urandom_range(5000)));
        2: bg = clamp_sample(ir_level + int'($urandom_range(5000)));
        default: bg = int'($urandom_range(SampleMax));
      endcase
      it = sample_set(ir_level, red_level, bg, $urandom_range(99) < 3);
    end
  endtask

  task automatic test_empty_envelopes();
    send_sample(sample_set(0, 0, 0, 1'b0));
    send_sample(sample_set(0, 0, SampleMax, 1'b0));
    send_sample(sample_set(SampleMax, SampleMax, 0, 1'b0));
    send_sample(sample_set(0, 0, SampleMax, 1'b0));
    send_sample(sample_set(0, SampleMax, 0, 1'b0));
  endtask

  task automatic test_equal_and_breakthrough();
    send_sample(sample_set(1000, 2000, 1000, 1'b1));
    send_sample(sample_set(1000, 2000, 999, 1'b0));
    send_sample(sample_set(5000, 500, 0, 1'b0));
    repeat (3) send_sample(sample_set(3000, 1500, 4000, 1'b0));
    send_sample(sample_set(18'h2AAAA, 18'h15555, 18'h15555, 1'b0));
    send_sample(sample_set(18'h15555, 18'h2AAAA, 18'h2AAAA, 1'b0));
    send_sample(sample_set(18'h15555, 18'h2AAAA, 18'h15555, 1'b0));
  endtask

  task automatic test_restart();
    send_sample(sample_set(0, 0, 0, 1'b1));
    send_sample(sample_set(123, 456, 100, 1'b0));
    send_sample(sample_set(40000, 50000, 30000, 1'b1));
  endtask

  task automatic test_min_step();
    set_follow_shift(shift_t'(15));
    send_sample(sample_set(100, 100, 0, 1'b1));
    send_sample(sample_set(200, 50, 0, 1'b0));
    repeat (2) send_sample(sample_set(150, 80, 0, 1'b0));
    set_follow_shift(shift_t'(0));
    send_sample(sample_set(1, SampleMax, 0, 1'b0));
    send_sample(sample_set(SampleMax, 1, 0, 1'b0));
  endtask

  task automatic test_random_tracking(input int count, input int send_pct, input int recv_pct);
    in_item_t it;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      make_random_item(it);
      send_sample(it);
      if (i % 200 == 199) begin
        hold_until_drained();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_envelopes();
    test_equal_and_breakthrough();
    test_restart();
    test_min_step();
    set_follow_shift(shift_t'(0));
    test_random_tracking(250, 6, 47);
    set_follow_shift(shift_t'(9));
    test_random_tracking(250, 6, 47);
    set_follow_shift(shift_t'(15));
    test_random_tracking(250, 47, 6);
    set_follow_shift(shift_t'(1));
    test_random_tracking(250, 47, 6);
    set_follow_shift(ShiftReset);
    test_random_tracking(250, 0, 0);
    set_follow_shift(shift_t'($urandom_range(15)));
    test_random_tracking(250, 0, 0);
    hold_until_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_spans.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
